// ----- rtl/core/pdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_pkg
// Widths, register indexes and fixed-point constants shared by the
// dual-channel PID drive block.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // Field widths
  localparam int POS_W   = 20;   // encoder position and target, signed degrees
  localparam int GAIN_W  = 24;   // unsigned Q0.24 gain
  localparam int ERR_W   = 21;   // target - position
  localparam int DER_W   = 22;   // error - previous error
  localparam int SUM_W   = 32;   // saturating integral
  localparam int SUM_X_W = SUM_W + 1;
  localparam int POW_W   = 13;   // signed Q5.8 volts
  localparam int CFG_W   = 24;   // widest register
  localparam int IDX_W   = 3;

  // Product widths: signed operand times zero-extended gain
  localparam int PP_W  = ERR_W + GAIN_W + 1;
  localparam int PD_W  = DER_W + GAIN_W + 1;
  localparam int PI_W  = SUM_W + GAIN_W + 1;
  localparam int ACC_W = PI_W + 1;

  // Q.24 to Q5.8 rounding
  localparam int FRAC_DROP  = 16;
  localparam int ROUND_HALF = 1 << (FRAC_DROP - 1);
  localparam int RND_W      = ACC_W - FRAC_DROP;

  localparam int POWER_LIMIT = 3072;   // 12 V in Q5.8

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_LEFT  = 3'd0,
    REG_TARGET_RIGHT = 3'd1,
    REG_GAIN_P_LEFT  = 3'd2,
    REG_GAIN_I_LEFT  = 3'd3,
    REG_GAIN_D_LEFT  = 3'd4,
    REG_GAIN_P_RIGHT = 3'd5,
    REG_GAIN_I_RIGHT = 3'd6,
    REG_GAIN_D_RIGHT = 3'd7
  } cfg_reg_t;

  // Gains of one side
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

endpackage
`default_nettype wire

// ----- rtl/core/pdr_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_in_if
// Sensor channel: one left and one right encoder position per transaction.
// ----------------------------------------------------------------------------
interface pdr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdr_pkg::POS_W-1:0]      left_position;
  logic signed [pdr_pkg::POS_W-1:0]      right_position;

  modport source (output valid, output left_position, output right_position, input ready);
  modport sink   (input valid, input left_position, input right_position, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pdr_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_out_if
// Drive channel: one left and one right power value per transaction.
// ----------------------------------------------------------------------------
interface pdr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdr_pkg::POW_W-1:0]      left_power;
  logic signed [pdr_pkg::POW_W-1:0]      right_power;

  modport source (output valid, output left_power, output right_power, input ready);
  modport sink   (input valid, input left_power, input right_power, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dual_channel_pid_drive.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_pid_drive
// Two independent position PID loops, left and right, with a register-write
// configuration port.
// ----------------------------------------------------------------------------
// Takes one sensor transaction per clock while in_ch.ready is high and returns
// one power transaction per sensor transaction, in order. An accepted
// transaction loads the error/integral register, then the gain product
// registers, then the output register; each stage holds while the one
// downstream is stalled. The block holds up to three transactions in flight
// and keeps a throughput of one per cycle while the output side takes
// results. Targets and gains are written through the cfg port; the user must
// write them only while no transaction is in flight, which the block does not
// enforce. All reset to zero.
// ----------------------------------------------------------------------------
module dual_channel_pid_drive (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  pdr_in_if.sink                            in_ch,
  pdr_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [pdr_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [pdr_pkg::CFG_W-1:0]    cfg_data
);

  // Configuration registers
  logic signed [pdr_pkg::POS_W-1:0] tgt_l_r;
  logic signed [pdr_pkg::POS_W-1:0] tgt_r_r;
  pdr_pkg::gains_t                  gains_l_r;
  pdr_pkg::gains_t                  gains_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_l_r   <= '0;
      tgt_r_r   <= '0;
      gains_l_r <= '0;
      gains_r_r <= '0;
    end else if (cfg_we) begin
      case (pdr_pkg::cfg_reg_t'(cfg_index))
        pdr_pkg::REG_TARGET_LEFT:  tgt_l_r      <= $signed(cfg_data[pdr_pkg::POS_W-1:0]);
        pdr_pkg::REG_TARGET_RIGHT: tgt_r_r      <= $signed(cfg_data[pdr_pkg::POS_W-1:0]);
        pdr_pkg::REG_GAIN_P_LEFT:  gains_l_r.kp <= cfg_data;
        pdr_pkg::REG_GAIN_I_LEFT:  gains_l_r.ki <= cfg_data;
        pdr_pkg::REG_GAIN_D_LEFT:  gains_l_r.kd <= cfg_data;
        pdr_pkg::REG_GAIN_P_RIGHT: gains_r_r.kp <= cfg_data;
        pdr_pkg::REG_GAIN_I_RIGHT: gains_r_r.ki <= cfg_data;
        pdr_pkg::REG_GAIN_D_RIGHT: gains_r_r.kd <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy: each stage loads when it is empty or its
  // downstream stage is taking its content
  logic a_v_r, b_v_r, o_v_r;
  logic take_o, take_b, take_a;
  logic in_fire, load_b, load_o;

  always_comb begin
    take_o  = !o_v_r || out_ch.ready;
    take_b  = !b_v_r || take_o;
    take_a  = !a_v_r || take_b;
    in_fire = in_ch.valid && take_a;
    load_b  = a_v_r && take_b;
    load_o  = b_v_r && take_o;
  end

  assign in_ch.ready = take_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= in_fire || (a_v_r && !take_b);
      b_v_r <= load_b  || (b_v_r && !take_o);
      o_v_r <= load_o  || (o_v_r && !out_ch.ready);
    end
  end

  // Left side
  logic signed [pdr_pkg::ERR_W-1:0] l_err;
  logic signed [pdr_pkg::DER_W-1:0] l_der;
  logic signed [pdr_pkg::SUM_W-1:0] l_sum;
  logic signed [pdr_pkg::PP_W-1:0]  l_pp;
  logic signed [pdr_pkg::PD_W-1:0]  l_pd;
  logic signed [pdr_pkg::PI_W-1:0]  l_pi;
  logic signed [pdr_pkg::POW_W-1:0] l_pow;

  pdr_err u_err_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (in_fire),
    .target   (tgt_l_r),
    .position (in_ch.left_position),
    .err_r    (l_err),
    .der_r    (l_der),
    .sum_r    (l_sum)
  );

  pdr_mul u_mul_l (
    .clk   (clk),
    .en    (load_b),
    .err   (l_err),
    .der   (l_der),
    .sum   (l_sum),
    .gains (gains_l_r),
    .pp_r  (l_pp),
    .pd_r  (l_pd),
    .pi_r  (l_pi)
  );

  pdr_out u_out_l (
    .clk     (clk),
    .en      (load_o),
    .pp      (l_pp),
    .pd      (l_pd),
    .pi      (l_pi),
    .power_r (l_pow)
  );

  // Right side
  logic signed [pdr_pkg::ERR_W-1:0] r_err;
  logic signed [pdr_pkg::DER_W-1:0] r_der;
  logic signed [pdr_pkg::SUM_W-1:0] r_sum;
  logic signed [pdr_pkg::PP_W-1:0]  r_pp;
  logic signed [pdr_pkg::PD_W-1:0]  r_pd;
  logic signed [pdr_pkg::PI_W-1:0]  r_pi;
  logic signed [pdr_pkg::POW_W-1:0] r_pow;

  pdr_err u_err_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (in_fire),
    .target   (tgt_r_r),
    .position (in_ch.right_position),
    .err_r    (r_err),
    .der_r    (r_der),
    .sum_r    (r_sum)
  );

  pdr_mul u_mul_r (
    .clk   (clk),
    .en    (load_b),
    .err   (r_err),
    .der   (r_der),
    .sum   (r_sum),
    .gains (gains_r_r),
    .pp_r  (r_pp),
    .pd_r  (r_pd),
    .pi_r  (r_pi)
  );

  pdr_out u_out_r (
    .clk     (clk),
    .en      (load_o),
    .pp      (r_pp),
    .pd      (r_pd),
    .pi      (r_pi),
    .power_r (r_pow)
  );

  assign out_ch.valid       = o_v_r;
  assign out_ch.left_power  = l_pow;
  assign out_ch.right_power = r_pow;

  // Loop state moves only on an accepted transaction
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(l_err) && $stable(l_sum) && $stable(r_err) && $stable(r_sum))
    else $error("loop state changed without an input transaction");

  // Left integral saturates rather than wrapping on a non-negative error
  a_sum_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (tgt_l_r >= in_ch.left_position) |=> l_sum >= $past(l_sum))
    else $error("left integral wrapped");

  // Presented power always within the 12 V limit
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> (l_pow <= 13'sd3072) && (l_pow >= -13'sd3072)
           && (r_pow <= 13'sd3072) && (r_pow >= -13'sd3072))
    else $error("power outside the saturation limit");

  // A stalled product stage keeps its transaction
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !take_o |=> b_v_r && $stable(l_pi) && $stable(r_pi))
    else $error("product stage dropped a transaction");

endmodule
`default_nettype wire

// ----- rtl/core/pdr_err.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_err
// Error stage of one side: error, derivative and saturating integral.
// The error register doubles as the previous-error state.
// ----------------------------------------------------------------------------
module pdr_err (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 en,
  input  wire logic signed [pdr_pkg::POS_W-1:0]     target,
  input  wire logic signed [pdr_pkg::POS_W-1:0]     position,
  output logic signed [pdr_pkg::ERR_W-1:0]          err_r,
  output logic signed [pdr_pkg::DER_W-1:0]          der_r,
  output logic signed [pdr_pkg::SUM_W-1:0]          sum_r
);

  logic signed [pdr_pkg::ERR_W-1:0]   err_nxt;
  logic signed [pdr_pkg::DER_W-1:0]   der_nxt;
  logic signed [pdr_pkg::SUM_X_W-1:0] sum_ext;
  logic signed [pdr_pkg::SUM_W-1:0]   sum_nxt;

  always_comb begin
    err_nxt = pdr_pkg::ERR_W'(target) - pdr_pkg::ERR_W'(position);
    der_nxt = pdr_pkg::DER_W'(err_nxt) - pdr_pkg::DER_W'(err_r);
    sum_ext = pdr_pkg::SUM_X_W'(sum_r) + pdr_pkg::SUM_X_W'(err_nxt);
    // clamp when the two top bits disagree
    if (sum_ext[pdr_pkg::SUM_X_W-1] != sum_ext[pdr_pkg::SUM_W-1]) begin
      sum_nxt = sum_ext[pdr_pkg::SUM_X_W-1] ?
                {1'b1, {(pdr_pkg::SUM_W-1){1'b0}}} :
                {1'b0, {(pdr_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_ext[pdr_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
      der_r <= '0;
      sum_r <= '0;
    end else if (en) begin
      err_r <= err_nxt;
      der_r <= der_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pdr_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_mul
// Product stage of one side: the three gain multiplies, each registered.
// ----------------------------------------------------------------------------
module pdr_mul (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [pdr_pkg::ERR_W-1:0]     err,
  input  wire logic signed [pdr_pkg::DER_W-1:0]     der,
  input  wire logic signed [pdr_pkg::SUM_W-1:0]     sum,
  input  wire pdr_pkg::gains_t                      gains,
  output logic signed [pdr_pkg::PP_W-1:0]           pp_r,
  output logic signed [pdr_pkg::PD_W-1:0]           pd_r,
  output logic signed [pdr_pkg::PI_W-1:0]           pi_r
);

  logic signed [pdr_pkg::PP_W-1:0] pp_nxt;
  logic signed [pdr_pkg::PD_W-1:0] pd_nxt;
  logic signed [pdr_pkg::PI_W-1:0] pi_nxt;

  // gains are unsigned: widen with a zero sign bit
  always_comb begin
    pp_nxt = pdr_pkg::PP_W'(err) * pdr_pkg::PP_W'($signed({1'b0, gains.kp}));
    pd_nxt = pdr_pkg::PD_W'(der) * pdr_pkg::PD_W'($signed({1'b0, gains.kd}));
    pi_nxt = pdr_pkg::PI_W'(sum) * pdr_pkg::PI_W'($signed({1'b0, gains.ki}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      pd_r <= pd_nxt;
      pi_r <= pi_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pdr_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_out
// Result stage of one side: sum the terms, round Q.24 to Q5.8 half up,
// clamp to +/-12 V.
// ----------------------------------------------------------------------------
module pdr_out (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [pdr_pkg::PP_W-1:0]      pp,
  input  wire logic signed [pdr_pkg::PD_W-1:0]      pd,
  input  wire logic signed [pdr_pkg::PI_W-1:0]      pi,
  output logic signed [pdr_pkg::POW_W-1:0]          power_r
);

  localparam logic signed [pdr_pkg::RND_W-1:0] POW_HI = pdr_pkg::RND_W'(pdr_pkg::POWER_LIMIT);
  localparam logic signed [pdr_pkg::RND_W-1:0] POW_LO = -POW_HI;

  logic signed [pdr_pkg::ACC_W-1:0] acc;
  logic signed [pdr_pkg::RND_W-1:0] rnd;
  logic signed [pdr_pkg::POW_W-1:0] power_nxt;

  always_comb begin
    acc = pdr_pkg::ACC_W'(pp) + pdr_pkg::ACC_W'(pd) + pdr_pkg::ACC_W'(pi)
        + pdr_pkg::ACC_W'(pdr_pkg::ROUND_HALF);
    rnd = $signed(acc[pdr_pkg::ACC_W-1:pdr_pkg::FRAC_DROP]);
    if (rnd > POW_HI) begin
      power_nxt = POW_HI[pdr_pkg::POW_W-1:0];
    end else if (rnd < POW_LO) begin
      power_nxt = POW_LO[pdr_pkg::POW_W-1:0];
    end else begin
      power_nxt = rnd[pdr_pkg::POW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      power_r <= power_nxt;
    end
  end

endmodule
`default_nettype wire
